// ===== src/lbu_pkg.sv =====
// ----------------------------------------------------------------------------
// lbu_pkg
// Shared constants and controller/datapath interface types for the LED
// bargraph level updater.
// ----------------------------------------------------------------------------
package lbu_pkg;

    localparam int LIGHT_W  = 22;
    localparam int LEVEL_W  = 5;
    localparam int ACTION_W = 3;
    localparam int ADDR_W   = 8;

    localparam int LEVEL_DIVISOR = 2184;
    localparam int LEVEL_MAX     = 24;
    localparam int ORANGE_FROM   = 9;
    localparam int RED_FROM      = 17;

    // Divide by 2184 as (light >> 3) / 273, done with a reciprocal multiply.
    localparam int PRE_SHIFT        = 3;
    localparam int DIV_SHIFT        = 21;
    localparam int DIV_RECIP        = 7682;
    localparam int CLAMP_FROM       = (LEVEL_MAX + 1) * LEVEL_DIVISOR;
    localparam int SCALED_W         = 13;
    localparam int PROD_W           = 2 * SCALED_W;

    localparam logic [ACTION_W-1:0] ACT_GREEN     = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_ORANGE    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_RED       = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR     = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_BLINK_ON  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_BLINK_OFF = 3'd5;

    typedef struct packed {
        logic capture;
        logic start;
        logic emit_seg;
        logic emit_blink;
        logic commit;
    } lbu_cmd_t;

    typedef struct packed {
        logic level_up;
        logic level_down;
        logic is_max;
        logic seg_final;
        logic slot_free;
    } lbu_status_t;

endpackage

// ===== src/lbu_datapath.sv =====
// ----------------------------------------------------------------------------
// lbu_datapath
// Level computation, shown level, segment cursor, address register and the
// command word output register.
// ----------------------------------------------------------------------------
module lbu_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [lbu_pkg::LIGHT_W-1:0]  light_level,
    input  logic                         cfg_write_en,
    input  logic [lbu_pkg::ADDR_W-1:0]   cfg_write_data,
    input  lbu_pkg::lbu_cmd_t            cmd,
    output lbu_pkg::lbu_status_t         status,
    output logic                         cmd_valid,
    input  logic                         cmd_ready,
    output logic [lbu_pkg::ACTION_W-1:0] action,
    output logic [lbu_pkg::LEVEL_W-1:0]  segment,
    output logic [lbu_pkg::ADDR_W-1:0]   bus_address,
    output logic                         last
);
    import lbu_pkg::*;

    logic [LEVEL_W-1:0]  level_reg;
    logic [LEVEL_W-1:0]  shown_reg;
    logic [LEVEL_W-1:0]  cur_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic                valid_reg;
    logic [ACTION_W-1:0] action_reg;
    logic [LEVEL_W-1:0]  segment_reg;
    logic                last_reg;

    logic [SCALED_W-1:0] scaled;
    logic [PROD_W-1:0]   prod;
    logic [LEVEL_W-1:0]  quot;
    logic                over;
    logic [LEVEL_W-1:0]  level_next;
    logic [LEVEL_W-1:0]  seg_end;
    logic [ACTION_W-1:0] seg_action;
    logic                up;
    logic                down;
    logic                slot_free;

    assign scaled = light_level[PRE_SHIFT+SCALED_W-1:PRE_SHIFT];
    assign prod   = PROD_W'(scaled) * PROD_W'(DIV_RECIP);
    assign quot   = prod[DIV_SHIFT+LEVEL_W-1:DIV_SHIFT];
    assign over   = light_level >= LIGHT_W'(CLAMP_FROM);

    always_comb
    begin
        if (over)
            level_next = LEVEL_W'(LEVEL_MAX);
        else if (quot == '0)
            level_next = LEVEL_W'(1);
        else
            level_next = quot;
    end

    assign up        = level_reg > shown_reg;
    assign down      = level_reg < shown_reg;
    assign seg_end   = up ? level_reg : level_reg + LEVEL_W'(1);
    assign slot_free = !valid_reg || cmd_ready;

    always_comb
    begin
        if (down)
            seg_action = ACT_CLEAR;
        else if (cur_reg < LEVEL_W'(ORANGE_FROM))
            seg_action = ACT_GREEN;
        else if (cur_reg < LEVEL_W'(RED_FROM))
            seg_action = ACT_ORANGE;
        else
            seg_action = ACT_RED;
    end

    assign status.level_up   = up;
    assign status.level_down = down;
    assign status.is_max     = level_reg == LEVEL_W'(LEVEL_MAX);
    assign status.seg_final  = cur_reg == seg_end;
    assign status.slot_free  = slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shown_reg <= LEVEL_W'(1);
            addr_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
                shown_reg <= level_reg;
            if (cfg_write_en)
                addr_reg <= cfg_write_data;
            if (cmd.emit_seg || cmd.emit_blink)
                valid_reg <= 1'b1;
            else if (cmd_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            level_reg <= level_next;
        if (cmd.start)
            cur_reg <= up ? shown_reg + LEVEL_W'(1) : shown_reg;
        else if (cmd.emit_seg)
            cur_reg <= up ? cur_reg + LEVEL_W'(1) : cur_reg - LEVEL_W'(1);
        if (cmd.emit_seg)
        begin
            action_reg  <= seg_action;
            segment_reg <= cur_reg;
            last_reg    <= 1'b0;
        end
        else if (cmd.emit_blink)
        begin
            action_reg  <= status.is_max ? ACT_BLINK_ON : ACT_BLINK_OFF;
            segment_reg <= '0;
            last_reg    <= 1'b1;
        end
    end

    assign cmd_valid   = valid_reg;
    assign action      = action_reg;
    assign segment     = segment_reg;
    assign bus_address = addr_reg;
    assign last        = last_reg;

endmodule

// ===== src/lbu_controller.sv =====
// ----------------------------------------------------------------------------
// lbu_controller
// Sequences one light word: capture, set up the cursor, walk the segment
// commands, then the closing blink command unless the level stays at max.
// ----------------------------------------------------------------------------
module lbu_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 light_valid,
    output logic                 light_ready,
    input  lbu_pkg::lbu_status_t status,
    output lbu_pkg::lbu_cmd_t    cmd
);
    import lbu_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CALC  = 4'b0010,
        ST_SEG   = 4'b0100,
        ST_BLINK = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        light_ready     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                light_ready = 1'b1;
                if (light_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cmd.start = 1'b1;
                if (status.level_up || status.level_down)
                    state_next = ST_SEG;
                else if (!status.is_max)
                    state_next = ST_BLINK;
                else
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SEG:
            begin
                if (status.slot_free)
                begin
                    cmd.emit_seg = 1'b1;
                    if (status.seg_final)
                        state_next = ST_BLINK;
                end
            end
            ST_BLINK:
            begin
                if (status.slot_free)
                begin
                    cmd.emit_blink = 1'b1;
                    cmd.commit     = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== src/led_bargraph_level_updater.sv =====
// ----------------------------------------------------------------------------
// led_bargraph_level_updater
// Turns light level words into bargraph driver command words.
// ----------------------------------------------------------------------------
// Usage:
//   Light channel: light_valid / light_ready carry light_level. A word is
//   taken only when the previous one has produced all its commands.
//   Command channel: cmd_valid / cmd_ready carry action, segment,
//   bus_address and last; last marks the final command of a light word.
//   cfg_write_en / cfg_write_data load the driver bus address at any edge;
//   write it only while no light word is in flight.
// Timing:
//   The light word is captured and its level divided in the IDLE state, the
//   cursor is set up in CALC, then one command word per cycle while cmd_ready
//   stays high, emitted by the controller into a single output register. The
//   first command is registered from SEG or BLINK, after the CALC state.
// Reset: bus address clears to 0, the shown level returns to 1 and no
//   command is pending. A stalled receiver holds the output register and
//   the sequence pauses until it is taken.
// ----------------------------------------------------------------------------
module led_bargraph_level_updater (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         light_valid,
    output logic                         light_ready,
    input  logic [lbu_pkg::LIGHT_W-1:0]  light_level,
    input  logic                         cfg_write_en,
    input  logic [lbu_pkg::ADDR_W-1:0]   cfg_write_data,
    output logic                         cmd_valid,
    input  logic                         cmd_ready,
    output logic [lbu_pkg::ACTION_W-1:0] action,
    output logic [lbu_pkg::LEVEL_W-1:0]  segment,
    output logic [lbu_pkg::ADDR_W-1:0]   bus_address,
    output logic                         last
);
    import lbu_pkg::*;

    lbu_cmd_t    cmd;
    lbu_status_t status;

    lbu_controller u_controller (
        .clk         (clk),
        .rst_n       (rst_n),
        .light_valid (light_valid),
        .light_ready (light_ready),
        .status      (status),
        .cmd         (cmd)
    );

    lbu_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .light_level    (light_level),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .cmd            (cmd),
        .status         (status),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .action         (action),
        .segment        (segment),
        .bus_address    (bus_address),
        .last           (last)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        light_valid && light_ready |=> !light_ready)
        else $error("light word accepted while busy");

    a_blink_segment_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && (action == ACT_BLINK_ON || action == ACT_BLINK_OFF)
        |-> segment == '0)
        else $error("blink command with nonzero segment");

    a_last_is_blink: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && last |-> (action == ACT_BLINK_ON || action == ACT_BLINK_OFF))
        else $error("last flag on a segment command");

    a_segment_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !last |-> segment != '0 && segment <= LEVEL_W'(LEVEL_MAX))
        else $error("segment command out of range");

endmodule

// ===== tb/led_bargraph_level_updater_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led_bargraph_level_updater_test
// Feeds light level words to the bargraph level updater and checks every
// command word against a predicted command stream. Runs a directed sweep
// over the level boundaries first, then several bus address settings, each
// with random light words. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module led_bargraph_level_updater_test;
    import lbu_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_WORDS  = 100;
    localparam int MAX_GAP       = 12;
    localparam int PRINT_LIMIT   = 50;

    typedef struct {
        logic [ACTION_W-1:0] action;
        logic [LEVEL_W-1:0]  segment;
        logic [ADDR_W-1:0]   bus_address;
        logic                last;
    } bar_cmd_t;

    class bar_command_predictor;
        bar_cmd_t          expected_cmds[$];
        int unsigned       shown_level;
        logic [ADDR_W-1:0] bus_addr;
        int                errors;

        function new();
            shown_level = 1;
            bus_addr    = '0;
            errors      = 0;
        endfunction

        function void report_error(string msg);
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("%0t ns: mismatch: %s", $realtime, msg);
        endfunction

        function void set_address(logic [ADDR_W-1:0] addr);
            bus_addr = addr;
        endfunction

        function int outstanding();
            return expected_cmds.size();
        endfunction

        function void queue_cmd(logic [ACTION_W-1:0] act, int unsigned seg);
            bar_cmd_t c;
            c.action      = act;
            c.segment     = seg[LEVEL_W-1:0];
            c.bus_address = bus_addr;
            c.last        = 1'b0;
            expected_cmds.push_back(c);
        endfunction

        function void note_light(logic [LIGHT_W-1:0] light);
            int unsigned lvl;
            int unsigned seg;
            int          start;
            bar_cmd_t    tail;
            lvl   = int'(light) / LEVEL_DIVISOR;
            start = expected_cmds.size();
            if (lvl == 0)
                lvl = 1;
            if (lvl > LEVEL_MAX)
                lvl = LEVEL_MAX;
            if (lvl > shown_level) begin
                for (seg = shown_level + 1; seg <= lvl; seg++) begin
                    if (seg < ORANGE_FROM)
                        queue_cmd(ACT_GREEN, seg);
                    else if (seg < RED_FROM)
                        queue_cmd(ACT_ORANGE, seg);
                    else
                        queue_cmd(ACT_RED, seg);
                end
                if (lvl == LEVEL_MAX)
                    queue_cmd(ACT_BLINK_ON, 0);
            end
            else if (lvl < shown_level) begin
                for (seg = shown_level; seg > lvl; seg--)
                    queue_cmd(ACT_CLEAR, seg);
            end
            if (lvl != LEVEL_MAX)
                queue_cmd(ACT_BLINK_OFF, 0);
            if (expected_cmds.size() > start) begin
                tail      = expected_cmds.pop_back();
                tail.last = 1'b1;
                expected_cmds.push_back(tail);
            end
            shown_level = lvl;
        endfunction

        function void check_command(logic [ACTION_W-1:0] act, logic [LEVEL_W-1:0] seg,
                                    logic [ADDR_W-1:0] addr, logic lst);
            bar_cmd_t exp_cmd;
            if (expected_cmds.size() == 0) begin
                report_error($sformatf("unexpected command action=%0d segment=%0d",
                                       act, seg));
                return;
            end
            exp_cmd = expected_cmds.pop_front();
            if (act !== exp_cmd.action || seg !== exp_cmd.segment ||
                addr !== exp_cmd.bus_address || lst !== exp_cmd.last)
                report_error($sformatf(
                    "got action=%0d segment=%0d addr=%0h last=%0b, want %0d %0d %0h %0b",
                    act, seg, addr, lst, exp_cmd.action, exp_cmd.segment,
                    exp_cmd.bus_address, exp_cmd.last));
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                light_valid;
    logic                light_ready;
    logic [LIGHT_W-1:0]  light_level;
    logic                cfg_write_en;
    logic [ADDR_W-1:0]   cfg_write_data;
    logic                cmd_valid;
    logic                cmd_ready;
    logic [ACTION_W-1:0] action;
    logic [LEVEL_W-1:0]  segment;
    logic [ADDR_W-1:0]   bus_address;
    logic                last;

    bar_command_predictor sb = new();
    bit   light_quiet = 1'b0;
    bit   cmd_quiet   = 1'b0;
    int   cycle_count = 0;

    led_bargraph_level_updater dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .light_valid    (light_valid),
        .light_ready    (light_ready),
        .light_level    (light_level),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .action         (action),
        .segment        (segment),
        .bus_address    (bus_address),
        .last           (last)
    );

    always #2 clk = ~clk;

    task automatic send_light(logic [LIGHT_W-1:0] value);
        int gap;
        if ($urandom_range(0, 29) == 0)
            light_quiet = !light_quiet;
        gap = light_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            light_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        light_valid <= 1'b1;
        light_level <= value;
        do
            @(posedge clk);
        while (!light_ready);
        sb.note_light(value);
        @(negedge clk);
    endtask

    task automatic drain_commands();
        light_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_bus_address(logic [ADDR_W-1:0] addr);
        drain_commands();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= addr;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        sb.set_address(addr);
    endtask

    function automatic logic [LIGHT_W-1:0] pick_light();
        int unsigned r;
        int unsigned q;
        int          v;
        r = $urandom_range(0, 19);
        q = $urandom_range(0, LEVEL_MAX + 1);
        if (r < 14)
            v = q * LEVEL_DIVISOR + $urandom_range(0, LEVEL_DIVISOR - 1);
        else if (r < 17)
            v = $urandom_range(0, (1 << LIGHT_W) - 1);
        else begin
            v = q * LEVEL_DIVISOR - $urandom_range(0, 1);
            if (v < 0)
                v = 0;
        end
        return v[LIGHT_W-1:0];
    endfunction

    // sweep every boundary: hold, rise to max, repeat at max, full fall
    int directed_levels[] = '{
        0, 2183, 2184, 4367, 4368, 9 * 2184, 17 * 2184, 24 * 2184 - 1,
        24 * 2184, 24 * 2184, 4194303, 25 * 2184, 0, 4194303, 16 * 2184,
        8 * 2184, 8 * 2184 + 2183, 1, 23 * 2184, 22 * 2184, 2097152,
        9 * 2184 - 1, 17 * 2184 - 1, 1398101
    };

    logic [ADDR_W-1:0] phase_addrs[5];

    initial begin : cmd_sink
        int gap;
        cmd_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if ($urandom_range(0, 39) == 0)
                cmd_quiet = !cmd_quiet;
            gap = cmd_quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                cmd_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            cmd_ready <= 1'b1;
            do
                @(posedge clk);
            while (!cmd_valid);
            sb.check_command(action, segment, bus_address, last);
            @(negedge clk);
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        rst_n          = 1'b0;
        light_valid    = 1'b0;
        light_level    = '0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        phase_addrs    = '{8'hFF, 8'h00, ADDR_W'($urandom), ADDR_W'($urandom), 8'h80};
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_levels[i])
            send_light(directed_levels[i][LIGHT_W-1:0]);

        foreach (phase_addrs[p]) begin
            write_bus_address(phase_addrs[p]);
            repeat (RANDOM_WORDS) send_light(pick_light());
        end

        drain_commands();
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
